### rtl/bpse_pkg.sv
// bpse_pkg: shared types and constants of the box placement settle engine
// no dependencies
`timescale 1ns / 1ps
package bpse_pkg;
  localparam int MaxBoxes  = 64;
  localparam int CoordBits = 10;
  localparam int IdxBits   = $clog2(MaxBoxes);
  localparam int CntBits   = $clog2(MaxBoxes + 1);
  localparam int BoxBits   = 6 * CoordBits;
  localparam int ModeBits  = 2;
  localparam int KindBits  = 3;
  localparam int CfgIdxBits = 2;
  localparam int InBits    = 64;   // 60 padded to bytes
  localparam int OutBits   = 32;   // 30 padded to bytes

  localparam logic [ModeBits-1:0] FUNC_SETTLE = 2'd0;
  localparam logic [ModeBits-1:0] FUNC_PLACE  = 2'd1;
  localparam logic [ModeBits-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [KindBits-1:0] KIND_SETTLED = 3'd0;
  localparam logic [KindBits-1:0] KIND_CAND    = 3'd1;
  localparam logic [KindBits-1:0] KIND_NOCAND  = 3'd2;
  localparam logic [KindBits-1:0] KIND_FULL    = 3'd3;
  localparam logic [KindBits-1:0] KIND_CLEARED = 3'd4;

  localparam logic [CfgIdxBits-1:0] REG_LENGTH = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 2'd2;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t sz, sy, sx, pz, py, px;
  } box_t;

  // overlap of moving box with stored box, open intervals, full width sums
  function automatic logic hits(box_t m, box_t b);
    logic hx, hy, hz;
    hx = ({1'b0, m.px} < {1'b0, b.px} + {1'b0, b.sx}) &&
         ({1'b0, m.px} + {1'b0, m.sx} > {1'b0, b.px});
    hy = ({1'b0, m.py} < {1'b0, b.py} + {1'b0, b.sy}) &&
         ({1'b0, m.py} + {1'b0, m.sy} > {1'b0, b.py});
    hz = ({1'b0, m.pz} < {1'b0, b.pz} + {1'b0, b.sz}) &&
         ({1'b0, m.pz} + {1'b0, m.sz} > {1'b0, b.pz});
    return hx && hy && hz;
  endfunction
endpackage

### rtl/bpse_ram.sv
// bpse_ram: generic single port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
module bpse_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/box_placement_settle_engine.sv
// box_placement_settle_engine: top level, sequencer over the box store
// depends on bpse_pkg and bpse_ram
`timescale 1ns / 1ps
// The block holds up to MaxBoxes placed boxes in one ram and handles one item
// at a time. With more than one box stored, a settle item slides its point
// down along x, then z, then y, one unit per scan; each scan reads the stored
// boxes one per cycle through the single ram port, and a settle runs one scan
// per unit step taken (plus one scan per nonzero axis). Clear and rejected
// place items give their result from idle; a place item writes the box into the
// store, then emits its results. Results
// leave through an output register; up to three candidates are emitted for a
// place, tlast marks the final result of each item.
// Function code 3 is dropped with no result. There is no clearing pass.
module box_placement_settle_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_x, pos_y, pos_z, size_x, size_y, size_z, zero pad
  input  logic [bpse_pkg::InBits-1:0]     s_tdata,
  // func
  input  logic [bpse_pkg::ModeBits-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_x, out_y, out_z, zero pad
  output logic [bpse_pkg::OutBits-1:0]    m_tdata,
  // kind
  output logic [bpse_pkg::KindBits-1:0]   m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpse_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [bpse_pkg::CoordBits-1:0]  cfg_data
);
  import bpse_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EMIT, S_CAND} state_t;

  state_t              state;
  logic [CntBits-1:0]  count;
  coord_t              bin_len, bin_wid, bin_hgt;
  box_t                cur;          // moving box / placed box
  logic [1:0]          axis;         // 0 x, 1 z, 2 y
  logic [CntBits-1:0]  scan;         // boxes issued in this scan
  logic                rd_valid;     // ram data of this scan valid
  logic                hit;
  logic                moved;        // a decrement already happened on axis
  logic [2:0]          cand;         // pending candidates x, y, z

  logic                ram_we;
  logic [IdxBits-1:0]  ram_addr;
  box_t                ram_rd;

  bpse_ram #(.Width(BoxBits), .Depth(MaxBoxes)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cur), .rdata(ram_rd)
  );

  logic [ModeBits-1:0] in_func;
  box_t                in_box;
  assign in_func = s_tuser;
  assign in_box  = s_tdata[BoxBits-1:0];

  assign s_tready  = (state == S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign ram_we    = (state == S_EMIT) && (cand != 3'b000 || moved);
  assign ram_addr  = (state == S_EMIT) ? count[IdxBits-1:0] : scan[IdxBits-1:0];

  // coordinate of the sliding axis
  coord_t ax_val;
  always_comb begin
    case (axis)
      2'd0:    ax_val = cur.px;
      2'd1:    ax_val = cur.pz;
      default: ax_val = cur.py;
    endcase
  end

  logic [CoordBits:0] rx, ry, rz;
  assign rx = {1'b0, cur.px} + {1'b0, cur.sx};
  assign ry = {1'b0, cur.py} + {1'b0, cur.sy};
  assign rz = {1'b0, cur.pz} + {1'b0, cur.sz};

  logic hit_now;
  assign hit_now = hit || (rd_valid && hits(cur, ram_rd));

  function automatic box_t set_ax(box_t b, logic [1:0] a, coord_t v);
    box_t r;
    r = b;
    case (a)
      2'd0:    r.px = v;
      2'd1:    r.pz = v;
      default: r.py = v;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      bin_len  <= '1;
      bin_wid  <= '1;
      bin_hgt  <= '1;
      m_tvalid <= 1'b0;
      rd_valid <= 1'b0;
      cand     <= '0;
      moved    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LENGTH: bin_len <= cfg_data;
          REG_WIDTH:  bin_wid <= cfg_data;
          REG_HEIGHT: bin_hgt <= cfg_data;
          default: ;
        endcase
      end
      // the candidate state reloads the output register itself
      if (m_tvalid && m_tready && state != S_CAND) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cur <= in_box;
            case (in_func)
              FUNC_SETTLE: begin
                if (count > CntBits'(1)) begin
                  axis <= 2'd0; scan <= '0; rd_valid <= 1'b0; hit <= 1'b0;
                  moved <= 1'b0;
                  state <= S_SCAN;
                end else begin
                  m_tdata  <= {2'b00, in_box.pz, in_box.py, in_box.px};
                  m_tuser  <= KIND_SETTLED; m_tlast <= 1'b1; m_tvalid <= 1'b1;
                end
              end
              FUNC_PLACE: begin
                if (count >= CntBits'(MaxBoxes)) begin
                  m_tdata <= '0; m_tuser <= KIND_FULL; m_tlast <= 1'b1;
                  m_tvalid <= 1'b1;
                end else begin
                  moved <= 1'b1;   // marks a pending store write
                  cand  <= 3'b000;
                  state <= S_EMIT;
                end
              end
              FUNC_CLEAR: begin
                count <= '0;
                m_tdata <= '0; m_tuser <= KIND_CLEARED; m_tlast <= 1'b1;
                m_tvalid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // a zero coordinate skips the axis entirely
          if (ax_val == '0 && !moved) begin
            if (axis == 2'd2) begin
              m_tdata <= {2'b00, cur.pz, cur.py, cur.px};
              m_tuser <= KIND_SETTLED; m_tlast <= 1'b1; m_tvalid <= 1'b1;
              state <= S_IDLE;
            end else begin
              axis <= axis + 2'd1;
            end
          end else if (scan < count) begin
            scan <= scan + CntBits'(1);
            rd_valid <= 1'b1;
            hit <= hit_now;
          end else if (rd_valid) begin
            // last read data arrives now, resolve the trial position
            rd_valid <= 1'b0;
            scan <= '0;
            hit <= 1'b0;
            if (!hit_now && !(moved && ax_val == '0)) begin
              cur <= set_ax(cur, axis, ax_val - coord_t'(1));
              moved <= 1'b1;
            end else begin
              // hold at 0 when the floor is free, else step back up one from an overlap
              if (moved && !hit_now && ax_val == '0) begin
                cur <= set_ax(cur, axis, '0);
              end else if (ax_val != '1) begin
                cur <= set_ax(cur, axis, ax_val + coord_t'(1));
              end
              moved <= 1'b0;
              if (axis == 2'd2) state <= S_EMIT;
              else axis <= axis + 2'd1;
            end
          end
        end
        S_EMIT: begin
          if (moved) begin
            // place: write happens this cycle, then build candidates
            count <= count + CntBits'(1);
            moved <= 1'b0;
            cand  <= {rz < {1'b0, bin_hgt}, ry < {1'b0, bin_wid},
                      rx < {1'b0, bin_len}};
            state <= S_CAND;
          end else if (!m_tvalid) begin
            m_tdata <= {2'b00, cur.pz, cur.py, cur.px};
            m_tuser <= KIND_SETTLED; m_tlast <= 1'b1; m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CAND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (cand[0]) begin
              m_tdata <= {2'b00, cur.pz, cur.py, rx[CoordBits-1:0]};
              m_tuser <= KIND_CAND;
              m_tlast <= (cand[2:1] == 2'b00);
              cand[0] <= 1'b0;
              if (cand[2:1] == 2'b00) state <= S_IDLE;
            end else if (cand[1]) begin
              m_tdata <= {2'b00, cur.pz, ry[CoordBits-1:0], cur.px};
              m_tuser <= KIND_CAND;
              m_tlast <= !cand[2];
              cand[1] <= 1'b0;
              if (!cand[2]) state <= S_IDLE;
            end else if (cand[2]) begin
              m_tdata <= {2'b00, rz[CoordBits-1:0], cur.py, cur.px};
              m_tuser <= KIND_CAND;
              m_tlast <= 1'b1;
              cand[2] <= 1'b0;
              state <= S_IDLE;
            end else begin
              m_tdata <= '0; m_tuser <= KIND_NOCAND; m_tlast <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
